@@ hw/rtl/swdrm_pkg.sv @@
// ----------------------------------------------------------------------------
// swdrm_pkg
// shared types and constants of the sliding window drop rate monitor
// ----------------------------------------------------------------------------
package swdrm_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;
  localparam int unsigned TS_W           = 64;
  localparam int unsigned THR_W          = 7;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 7'd25;
  localparam logic [TS_W-1:0]  WINDOW_RST    = 64'd10000000000;
  localparam logic [TS_W-1:0]  INTERVAL_RST  = 64'd1000000000;

  localparam logic KIND_FRAME     = 1'b0;
  localparam logic KIND_SET_CHECK = 1'b1;

  // multiplier applied to the dropped count in the rate compare
  localparam logic [THR_W-1:0] PERCENT_SCALE = 7'd100;

  typedef struct packed {
    logic            kind;
    logic            sent;
    logic [TS_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [TS_W-1:0]  window;
    logic [TS_W-1:0]  interval;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OVF,
    S_WRITE,
    S_EV_WAIT,
    S_EV_CHK,
    S_OUT
  } back_state_t;

endpackage

@@ hw/rtl/sliding_window_drop_rate_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_drop_rate_monitor_unit
// frame drop rate monitor over a sliding time window with periodic checks
// ----------------------------------------------------------------------------
// latency (item accept to result accept) follows the state path: a set-check item goes
// from idle to output, a frame without a check through write, a check through write and
// a wait and check state pair per evicted frame plus a final pair; overflow adds ovf
// the back end takes a new item only in idle; eviction waits on the registered ring read
// the two entry front queue accepts items while a result waits on the output, until full
// reset: synchronous, clears counts, pointers, check time and config to defaults
module sliding_window_drop_rate_monitor_unit #(
  parameter int unsigned RING_DEPTH = swdrm_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [swdrm_pkg::TS_W-1:0]      timestamp,
  input  logic                            sent,
  input  logic [swdrm_pkg::TS_W-1:0]      check_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            above_threshold,
  output logic                            checked,
  output logic                            overflow,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swdrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swdrm_pkg::TS_W-1:0]      cfg_data
);
  import swdrm_pkg::*;

  cfg_t cfg;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RST;
      cfg.window    <= WINDOW_RST;
      cfg.interval  <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        CFG_WINDOW:    cfg.window    <= cfg_data;
        CFG_INTERVAL:  cfg.interval  <= cfg_data;
        default:       cfg           <= cfg;
      endcase
    end
  end

  swdrm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .timestamp  (timestamp),
    .sent       (sent),
    .check_time (check_time),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  swdrm_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .above_threshold (above_threshold),
    .checked         (checked),
    .overflow        (overflow)
  );

endmodule

@@ hw/rtl/swdrm_ram.sv @@
// ----------------------------------------------------------------------------
// swdrm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module swdrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/swdrm_front.sv @@
// ----------------------------------------------------------------------------
// swdrm_front
// input handshake, item classification and a two entry command queue
// ----------------------------------------------------------------------------
module swdrm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [swdrm_pkg::TS_W-1:0]   timestamp,
  input  logic                         sent,
  input  logic [swdrm_pkg::TS_W-1:0]   check_time,
  output logic                         q_valid,
  output swdrm_pkg::cmd_t              q_cmd,
  input  logic                         q_pop
);
  import swdrm_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;
  cmd_t       cmd_in;

  assign in_stall = (q_cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_cnt != 2'd0);
  assign q_cmd    = q_mem[rd_ptr];

  // one value field carries either the frame time or the new check time
  always_comb begin
    cmd_in.kind  = kind;
    cmd_in.sent  = (kind == KIND_FRAME) ? sent : 1'b0;
    cmd_in.value = (kind == KIND_SET_CHECK) ? check_time : timestamp;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

endmodule

@@ hw/rtl/swdrm_back.sv @@
// ----------------------------------------------------------------------------
// swdrm_back
// frame ring, running counts, eviction walk and drop rate check
// ----------------------------------------------------------------------------
module swdrm_back #(
  parameter int unsigned RING_DEPTH = swdrm_pkg::RING_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  swdrm_pkg::cfg_t cfg,
  input  logic            q_valid,
  input  swdrm_pkg::cmd_t q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            above_threshold,
  output logic            checked,
  output logic            overflow
);
  import swdrm_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned PW = CW + THR_W;

  back_state_t     state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   dropped, dropped_next;
  logic [TS_W-1:0] nct, nct_next;
  logic [TS_W-1:0] ts, ts_next;
  logic            sent_r, sent_r_next;
  logic [TS_W-1:0] bound, bound_next;
  logic            ovf, ovf_next;
  logic            res_above, res_above_next;
  logic            res_checked, res_checked_next;
  logic            res_ovf, res_ovf_next;

  logic            we;
  logic [AW-1:0]   slot;
  logic [CW:0]     slot_sum;
  logic [AW-1:0]   head_inc;
  logic [TS_W:0]   nct_sum;
  logic [TS_W-1:0] nct_sat;
  logic [PW-1:0]   lhs;
  logic [PW-1:0]   rhs;
  logic [TS_W:0]   rdata;
  logic [TS_W-1:0] head_time;
  logic            head_sent;

  swdrm_ram #(
    .WIDTH (TS_W + 1),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata ({ts, sent_r}),
    .raddr (head),
    .rdata (rdata)
  );

  assign head_time = rdata[TS_W:1];
  assign head_sent = rdata[0];

  always_comb begin
    slot_sum = (CW + 1)'(head) + (CW + 1)'(count);
    if (slot_sum >= (CW + 1)'(RING_DEPTH)) begin
      slot_sum = slot_sum - (CW + 1)'(RING_DEPTH);
    end
    slot     = slot_sum[AW-1:0];
    head_inc = (head == AW'(RING_DEPTH - 1)) ? '0 : head + AW'(1);
    nct_sum  = {1'b0, ts} + {1'b0, cfg.interval};
    nct_sat  = nct_sum[TS_W] ? '1 : nct_sum[TS_W-1:0];
    lhs      = PW'(dropped) * PW'(PERCENT_SCALE);
    rhs      = PW'(cfg.threshold) * PW'(count);
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    dropped_next     = dropped;
    nct_next         = nct;
    ts_next          = ts;
    sent_r_next      = sent_r;
    bound_next       = bound;
    ovf_next         = ovf;
    res_above_next   = res_above;
    res_checked_next = res_checked;
    res_ovf_next     = res_ovf;
    q_pop            = 1'b0;
    we               = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          ts_next     = q_cmd.value;
          sent_r_next = q_cmd.sent;
          ovf_next    = 1'b0;
          if (q_cmd.kind == KIND_SET_CHECK) begin
            nct_next         = q_cmd.value;
            res_above_next   = 1'b0;
            res_checked_next = 1'b0;
            res_ovf_next     = 1'b0;
            state_next       = S_OUT;
          end else if (count == CW'(RING_DEPTH)) begin
            state_next = S_OVF;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_OVF: begin
        if (!head_sent && dropped != '0) begin
          dropped_next = dropped - CW'(1);
        end
        head_next  = head_inc;
        count_next = count - CW'(1);
        ovf_next   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        we         = 1'b1;
        count_next = count + CW'(1);
        if (!sent_r) begin
          dropped_next = dropped + CW'(1);
        end
        if (ts >= nct) begin
          bound_next = (ts >= cfg.window) ? ts - cfg.window : '0;
          state_next = S_EV_WAIT;
        end else begin
          res_above_next   = 1'b0;
          res_checked_next = 1'b0;
          res_ovf_next     = ovf;
          state_next       = S_OUT;
        end
      end
      S_EV_WAIT: begin
        state_next = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (count != '0 && head_time < bound) begin
          if (!head_sent && dropped != '0) begin
            dropped_next = dropped - CW'(1);
          end
          head_next  = head_inc;
          count_next = count - CW'(1);
          state_next = S_EV_WAIT;
        end else begin
          res_above_next   = (lhs >= rhs);
          res_checked_next = 1'b1;
          res_ovf_next     = ovf;
          nct_next         = nct_sat;
          state_next       = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      dropped <= '0;
      nct     <= '0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      count   <= count_next;
      dropped <= dropped_next;
      nct     <= nct_next;
    end
  end

  always_ff @(posedge clk) begin
    ts          <= ts_next;
    sent_r      <= sent_r_next;
    bound       <= bound_next;
    ovf         <= ovf_next;
    res_above   <= res_above_next;
    res_checked <= res_checked_next;
    res_ovf     <= res_ovf_next;
  end

  assign out_valid       = (state == S_OUT);
  assign above_threshold = res_above;
  assign checked         = res_checked;
  assign overflow        = res_ovf;

endmodule

@@ hw/rtl/swdrm_checker.sv @@
// ----------------------------------------------------------------------------
// swdrm_checker
// port level checks of the drop rate monitor, bound to the top level
// ----------------------------------------------------------------------------
module swdrm_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic above_threshold,
  input logic checked,
  input logic overflow
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(above_threshold)
      && $stable(checked) && $stable(overflow))
    else $error("result changed while stalled");

  // the rate flag only comes with a check
  a_above_needs_check: assert property (@(posedge clk) disable iff (rst)
    out_valid && !checked |-> !above_threshold)
    else $error("above_threshold without a check");

  // nothing is pending out of reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // the input queue accepts items out of reset
  a_reset_in: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind sliding_window_drop_rate_monitor_unit swdrm_checker u_swdrm_checker (.*);
